@@ src/bpqm_pkg.sv @@
`default_nettype none

package bpqm_pkg;

    typedef enum logic [1:0]
    {
        MODE_ALLOC   = 2'd0,
        MODE_APPEND  = 2'd1,
        MODE_FETCH   = 2'd2,
        MODE_RELEASE = 2'd3
    } mode_t;

    typedef enum logic [1:0]
    {
        ST_INIT,
        ST_IDLE,
        ST_FINISH,
        ST_HOLD
    } state_t;

    typedef struct packed
    {
        mode_t      mode;
        logic [3:0] block;
    } cmd_t;

    typedef struct packed
    {
        logic       granted;
        logic [3:0] block_out;
    } res_t;

endpackage

`default_nettype wire

@@ src/bpqm_link_ram.sv @@
`default_nettype none

module bpqm_link_ram
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 5
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/bpqm_ctrl.sv @@
`default_nettype none

module bpqm_ctrl
#(
    parameter int NUM_BLOCKS = 16,
    parameter int IDX_W      = 4
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    output logic                  cmd_ready,
    input  wire bpqm_pkg::cmd_t   cmd,
    output logic                  mem_we,
    output logic [IDX_W-1:0]      mem_waddr,
    output logic [IDX_W:0]        mem_wdata,
    output logic                  mem_re,
    output logic [IDX_W-1:0]      mem_raddr,
    input  wire logic [IDX_W:0]   mem_rdata,
    input  wire logic             slot_free,
    output logic                  push,
    output bpqm_pkg::res_t        push_data
);

    import bpqm_pkg::*;

    localparam int WIDE_W = IDX_W + 5;

    state_t            state_reg,    state_next;
    mode_t             op_reg,       op_next;
    logic [3:0]        blk_reg,      blk_next;
    logic [IDX_W-1:0]  init_cnt_reg, init_cnt_next;
    logic [IDX_W-1:0]  free_top_reg, free_top_next;
    logic              free_ne_reg,  free_ne_next;
    logic [IDX_W-1:0]  q_head_reg,   q_head_next;
    logic [IDX_W-1:0]  q_tail_reg,   q_tail_next;
    logic              q_ne_reg,     q_ne_next;
    res_t              pend_reg,     pend_next;

    logic              cmd_in_range;
    logic              blk_in_range;
    logic [IDX_W-1:0]  cmd_idx;
    logic [IDX_W-1:0]  blk_idx;
    logic              rd_valid;
    logic [IDX_W-1:0]  rd_idx;

    assign cmd_idx      = IDX_W'(cmd.block);
    assign blk_idx      = IDX_W'(blk_reg);
    assign cmd_in_range = WIDE_W'(cmd.block) < WIDE_W'(NUM_BLOCKS);
    assign blk_in_range = WIDE_W'(blk_reg) < WIDE_W'(NUM_BLOCKS);
    assign rd_valid     = mem_rdata[IDX_W];
    assign rd_idx       = mem_rdata[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            init_cnt_reg <= '0;
            free_top_reg <= IDX_W'(NUM_BLOCKS - 1);
            free_ne_reg  <= 1'b1;
            q_head_reg   <= '0;
            q_tail_reg   <= '0;
            q_ne_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            init_cnt_reg <= init_cnt_next;
            free_top_reg <= free_top_next;
            free_ne_reg  <= free_ne_next;
            q_head_reg   <= q_head_next;
            q_tail_reg   <= q_tail_next;
            q_ne_reg     <= q_ne_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        blk_reg  <= blk_next;
        pend_reg <= pend_next;
    end

    always_comb
    begin
        res_t res;

        state_next    = state_reg;
        op_next       = op_reg;
        blk_next      = blk_reg;
        init_cnt_next = init_cnt_reg;
        free_top_next = free_top_reg;
        free_ne_next  = free_ne_reg;
        q_head_next   = q_head_reg;
        q_tail_next   = q_tail_reg;
        q_ne_next     = q_ne_reg;
        pend_next     = pend_reg;
        res           = '0;
        cmd_ready     = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = '0;
        push          = 1'b0;
        push_data     = '0;

        case (state_reg)
            ST_INIT:
            begin
                // Each block but block 0 starts linked to the one below it; block 0 ends the list.
                mem_we    = 1'b1;
                mem_waddr = init_cnt_reg;
                if (init_cnt_reg != '0)
                begin
                    mem_wdata = {1'b1, init_cnt_reg - 1'b1};
                end
                init_cnt_next = init_cnt_reg + 1'b1;
                if (init_cnt_reg == IDX_W'(NUM_BLOCKS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    op_next    = cmd.mode;
                    blk_next   = cmd.block;
                    state_next = ST_FINISH;
                    case (cmd.mode)
                        MODE_ALLOC:
                        begin
                            mem_re    = free_ne_reg;
                            mem_raddr = free_top_reg;
                        end
                        MODE_FETCH:
                        begin
                            mem_re    = q_ne_reg;
                            mem_raddr = q_head_reg;
                        end
                        MODE_APPEND:
                        begin
                            mem_we    = cmd_in_range;
                            mem_waddr = cmd_idx;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_FINISH:
            begin
                case (op_reg)
                    MODE_ALLOC:
                    begin
                        if (free_ne_reg)
                        begin
                            mem_we        = 1'b1;
                            mem_waddr     = free_top_reg;
                            free_top_next = rd_valid ? rd_idx : '0;
                            free_ne_next  = rd_valid;
                            res           = '{granted: 1'b1, block_out: 4'(free_top_reg)};
                        end
                    end
                    MODE_FETCH:
                    begin
                        if (q_ne_reg)
                        begin
                            mem_we      = 1'b1;
                            mem_waddr   = q_head_reg;
                            q_head_next = rd_valid ? rd_idx : '0;
                            if (!rd_valid)
                            begin
                                q_tail_next = '0;
                                q_ne_next   = 1'b0;
                            end
                            res = '{granted: 1'b1, block_out: 4'(q_head_reg)};
                        end
                    end
                    MODE_APPEND:
                    begin
                        if (blk_in_range)
                        begin
                            if (!q_ne_reg)
                            begin
                                q_head_next = blk_idx;
                                q_ne_next   = 1'b1;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = q_tail_reg;
                                mem_wdata = {1'b1, blk_idx};
                            end
                            q_tail_next = blk_idx;
                            res.granted = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (blk_in_range)
                        begin
                            mem_we        = 1'b1;
                            mem_waddr     = blk_idx;
                            mem_wdata     = {free_ne_reg,
                                             free_ne_reg ? free_top_reg : IDX_W'(0)};
                            free_top_next = blk_idx;
                            free_ne_next  = 1'b1;
                            res.granted   = 1'b1;
                        end
                    end
                endcase

                if (slot_free)
                begin
                    push       = 1'b1;
                    push_data  = res;
                    state_next = ST_IDLE;
                end
                else
                begin
                    pend_next  = res;
                    state_next = ST_HOLD;
                end
            end

            ST_HOLD:
            begin
                if (slot_free)
                begin
                    push       = 1'b1;
                    push_data  = pend_reg;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("link store read and written in the same cycle");

    a_free_empty_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        !free_ne_reg |-> free_top_reg == '0)
        else $error("free list empty but top pointer not cleared");

    a_queue_empty_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        !q_ne_reg |-> (q_head_reg == '0) && (q_tail_reg == '0))
        else $error("queue empty but head or tail pointer not cleared");

    a_accept_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> state_reg == ST_FINISH)
        else $error("accepted request not followed by its finishing cycle");

    a_push_state: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> slot_free && (state_reg == ST_FINISH || state_reg == ST_HOLD))
        else $error("result pushed outside a finishing cycle or into a full slot");

endmodule

`default_nettype wire

@@ src/block_pool_queue_manager.sv @@
// Channel   Payload              Handshake               Carries
// cmd       bpqm_pkg::cmd_t      cmd_valid / cmd_ready   operation and block index
// res       bpqm_pkg::res_t      res_valid / res_ready   grant flag and block index
//
// A request passes through ST_IDLE, where the link store is read (for an append,
// written; a release leaves it) as it is taken, then ST_FINISH, where the dependent
// pointer update and write-back follow, using the registered read data of the link store.
// After reset an initialisation pass writes every one of the NUM_BLOCKS entries of
// the link store, during which cmd_ready stays low.
// A result waits in the output register while the next request is taken; a
// second finished result is held until the first has been collected.
`default_nettype none

module block_pool_queue_manager
#(
    parameter int NUM_BLOCKS = 16
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_ready,
    input  wire bpqm_pkg::cmd_t cmd,
    output logic                res_valid,
    input  wire logic           res_ready,
    output bpqm_pkg::res_t      res
);

    import bpqm_pkg::*;

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [IDX_W:0]    mem_wdata;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    logic [IDX_W:0]    mem_rdata;
    logic              slot_free;
    logic              push;
    res_t              push_data;

    logic              res_valid_reg, res_valid_next;
    res_t              res_reg,       res_next;

    bpqm_ctrl
    #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .IDX_W      (IDX_W)
    )
    u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .slot_free (slot_free),
        .push      (push),
        .push_data (push_data)
    );

    bpqm_link_ram
    #(
        .DEPTH  (NUM_BLOCKS),
        .ADDR_W (IDX_W),
        .DATA_W (IDX_W + 1)
    )
    u_link_ram
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign slot_free = !res_valid_reg || res_ready;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (push)
        begin
            res_valid_next = 1'b1;
            res_next       = push_data;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

@@ test/tb_block_pool_queue_manager.sv @@
`default_nettype none

module tb_block_pool_queue_manager;

    import bpqm_pkg::*;

    localparam int NUM_BLOCKS   = 16;
    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_ITEMS = 1550;
    localparam int HOLD_CYCLES  = 80;

    typedef struct packed
    {
        cmd_t c;
        logic known;
        res_t want;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [20] = '{
        '{'{MODE_FETCH,   4'd0},  1'b1, '{1'b0, 4'd0}},
        '{'{MODE_ALLOC,   4'd15}, 1'b1, '{1'b1, 4'd15}},
        '{'{MODE_ALLOC,   4'd0},  1'b1, '{1'b1, 4'd14}},
        '{'{MODE_APPEND,  4'd15}, 1'b1, '{1'b1, 4'd0}},
        '{'{MODE_APPEND,  4'd14}, 1'b1, '{1'b1, 4'd0}},
        '{'{MODE_FETCH,   4'd0},  1'b0, '{1'b0, 4'd0}},
        '{'{MODE_FETCH,   4'd0},  1'b0, '{1'b0, 4'd0}},
        '{'{MODE_FETCH,   4'd15}, 1'b1, '{1'b0, 4'd0}},
        '{'{MODE_RELEASE, 4'd15}, 1'b1, '{1'b1, 4'd0}},
        '{'{MODE_RELEASE, 4'd0},  1'b1, '{1'b1, 4'd0}},
        '{'{MODE_ALLOC,   4'd0},  1'b0, '{1'b0, 4'd0}},
        '{'{MODE_ALLOC,   4'd0},  1'b0, '{1'b0, 4'd0}},
        '{'{MODE_APPEND,  4'd0},  1'b1, '{1'b1, 4'd0}},
        '{'{MODE_APPEND,  4'd0},  1'b1, '{1'b1, 4'd0}},
        '{'{MODE_FETCH,   4'd0},  1'b0, '{1'b0, 4'd0}},
        '{'{MODE_FETCH,   4'd0},  1'b0, '{1'b0, 4'd0}},
        '{'{MODE_RELEASE, 4'd0},  1'b1, '{1'b1, 4'd0}},
        '{'{MODE_RELEASE, 4'd0},  1'b1, '{1'b1, 4'd0}},
        '{'{MODE_ALLOC,   4'd0},  1'b0, '{1'b0, 4'd0}},
        '{'{MODE_ALLOC,   4'd0},  1'b0, '{1'b0, 4'd0}}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    logic res_valid;
    logic res_ready;
    res_t res;

    bit       link_ok [NUM_BLOCKS];
    bit [3:0] link_to [NUM_BLOCKS];
    bit [3:0] free_top;
    bit       free_any;
    bit [3:0] q_head;
    bit [3:0] q_tail;
    bit       q_any;

    res_t        owed_results [$];
    bit [3:0]    held_blocks [$];
    bit [3:0]    fetched_blocks [$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int          rx_hold_left = 0;
    bit          calm = 1'b0;

    block_pool_queue_manager #(.NUM_BLOCKS(NUM_BLOCKS)) DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic res_t pool_step(cmd_t c);
        res_t     r;
        bit [3:0] b;
        r = '0;
        case (c.mode)
            MODE_ALLOC:
            begin
                if (free_any)
                begin
                    b = free_top;
                    if (link_ok[b])
                        free_top = link_to[b];
                    else
                    begin
                        free_top = '0;
                        free_any = 1'b0;
                    end
                    link_ok[b] = 1'b0;
                    link_to[b] = '0;
                    r.granted = 1'b1;
                    r.block_out = b;
                end
            end
            MODE_APPEND:
            begin
                if (int'(c.block) < NUM_BLOCKS)
                begin
                    link_ok[c.block] = 1'b0;
                    link_to[c.block] = '0;
                    if (!q_any)
                    begin
                        q_head = c.block;
                        q_tail = c.block;
                        q_any = 1'b1;
                    end
                    else
                    begin
                        link_ok[q_tail] = 1'b1;
                        link_to[q_tail] = c.block;
                        q_tail = c.block;
                    end
                    r.granted = 1'b1;
                end
            end
            MODE_FETCH:
            begin
                if (q_any)
                begin
                    b = q_head;
                    if (link_ok[b])
                        q_head = link_to[b];
                    else
                    begin
                        q_head = '0;
                        q_tail = '0;
                        q_any = 1'b0;
                    end
                    link_ok[b] = 1'b0;
                    link_to[b] = '0;
                    r.granted = 1'b1;
                    r.block_out = b;
                end
            end
            default:
            begin
                if (int'(c.block) < NUM_BLOCKS)
                begin
                    link_ok[c.block] = free_any;
                    link_to[c.block] = free_any ? free_top : 4'd0;
                    free_top = c.block;
                    free_any = 1'b1;
                    r.granted = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    function automatic cmd_t pick_request(int phase);
        cmd_t c;
        int   w;
        int   k;
        c.mode = mode_t'(2'($urandom_range(3)));
        c.block = 4'($urandom_range(15));
        if ($urandom_range(99) < 8)
            return c;
        w = $urandom_range(99);
        case (phase)
            0: c.mode = (w < 45) ? MODE_ALLOC : (w < 80) ? MODE_APPEND :
                        (w < 92) ? MODE_FETCH : MODE_RELEASE;
            1: c.mode = (w < 10) ? MODE_ALLOC : (w < 25) ? MODE_APPEND :
                        (w < 70) ? MODE_FETCH : MODE_RELEASE;
            default: c.mode = mode_t'(2'(w % 4));
        endcase
        if (c.mode == MODE_APPEND && held_blocks.size() != 0)
        begin
            k = $urandom_range(held_blocks.size() - 1);
            c.block = held_blocks[k];
            held_blocks.delete(k);
        end
        else if (c.mode == MODE_RELEASE && fetched_blocks.size() != 0)
        begin
            k = $urandom_range(fetched_blocks.size() - 1);
            c.block = fetched_blocks[k];
            fetched_blocks.delete(k);
        end
        return c;
    endfunction

    task automatic issue(input cmd_t c, input bit known, input res_t want);
        res_t r;
        cmd_valid <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (!cmd_ready);
        r = pool_step(c);
        owed_results.push_back(known ? want : r);
        if (r.granted && c.mode == MODE_ALLOC)
            held_blocks.push_back(r.block_out);
        if (r.granted && c.mode == MODE_FETCH)
            fetched_blocks.push_back(r.block_out);
    endtask

    task automatic sender_gap(input bit drain);
        if (drain || (!calm && $urandom_range(99) < 31))
        begin
            cmd_valid <= 1'b0;
            do
                @(posedge clk);
            while (drain && owed_results.size() != 0);
            while (!calm && $urandom_range(99) < 31)
                @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cmd_valid <= 1'b0;
        cmd <= '0;
        for (int i = 0; i < NUM_BLOCKS; i++)
        begin
            link_ok[i] = (i != 0);
            link_to[i] = (i != 0) ? 4'(i - 1) : 4'd0;
        end
        free_top = 4'(NUM_BLOCKS - 1);
        free_any = 1'b1;
        q_head = '0;
        q_tail = '0;
        q_any = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (DIR_ROWS[i])
        begin
            sender_gap(1'b0);
            issue(DIR_ROWS[i].c, DIR_ROWS[i].known, DIR_ROWS[i].want);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 300)
                rx_hold_left = HOLD_CYCLES;
            calm = (i >= 900 && i < 1100);
            sender_gap(i == 700 || i == 1300);
            issue(pick_request((i / 120) % 3), 1'b0, '0);
        end
        cmd_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("block_pool_queue_manager: match");
        else
            $display("block_pool_queue_manager: mismatch");
        $finish;
    end

    initial
    begin
        res_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_left > 0)
            begin
                res_ready <= 1'b0;
                rx_hold_left--;
            end
            else
                res_ready <= calm || ($urandom_range(99) >= 31);
        end
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (owed_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: granted %0b block_out %0d",
                             res.granted, res.block_out);
            end
            else
            begin
                want = owed_results.pop_front();
                if (res.granted !== want.granted || res.block_out !== want.block_out)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Wrong result: expected granted %0b block_out %0d, %s",
                                 want.granted, want.block_out,
                                 $sformatf("got granted %0b block_out %0d",
                                           res.granted, res.block_out));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("block_pool_queue_manager: mismatch");
            $finish;
        end
    end

endmodule

`default_nettype wire
